[sv/btc_pkg.sv]
// Shared constants, register indexes and helpers for the baro compensation core.
`default_nettype none
package btc_pkg;

  localparam int unsigned DW = 32;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } cfg_reg_t;

  localparam logic [31:0] RST_AC1_AC2 = 32'h0198_FFB8;
  localparam logic [31:0] RST_AC3_AC4 = 32'hC7D1_7FE5;
  localparam logic [31:0] RST_AC5_AC6 = 32'h7FF5_5A71;
  localparam logic [31:0] RST_B1_B2   = 32'h182E_0004;
  localparam logic [31:0] RST_MC_MD   = 32'hDDF9_0B34;
  localparam logic [1:0]  RST_OSS     = 2'd0;

  localparam logic [31:0] K_B6_OFS  = 32'd4000;
  localparam logic [31:0] K_HALF    = 32'd32768;
  localparam logic [31:0] K_P_SCALE = 32'd50000;
  localparam logic [31:0] K_C3038   = 32'd3038;
  localparam logic [31:0] K_CM7357  = 32'hFFFF_E343; // -7357
  localparam logic [31:0] K_C3791   = 32'd3791;
  localparam logic [31:0] P_MAX     = 32'd262143;

  // arithmetic right shift of a 32-bit word
  function automatic logic [31:0] sra32(input logic [31:0] x, input logic [4:0] n);
    return 32'($signed(x) >>> n);
  endfunction

  // low word of a 32x32 product
  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] f;
    f = a * b;
    return f[31:0];
  endfunction

  // sign-extend a 16-bit half word
  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

[sv/btc_div_pipe.sv]
// Pipelined unsigned 32/32 restoring divider, one quotient bit per stage.
`default_nettype none
module btc_div_pipe #(
  parameter int unsigned SIDE_W = 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_valid,
  input  wire logic [31:0]         in_dividend,
  input  wire logic [31:0]         in_divisor,
  input  wire logic [SIDE_W-1:0]   in_side,
  output logic                     out_valid,
  output logic [31:0]              out_quotient,
  output logic [SIDE_W-1:0]        out_side
);

  localparam int unsigned N = btc_pkg::DW;

  logic [N:0]        vld_r;
  logic [31:0]       rem_r  [0:N];
  logic [31:0]       dq_r   [0:N];
  logic [31:0]       dvs_r  [0:N];
  logic [SIDE_W-1:0] side_r [0:N];

  // capture stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      dq_r[0]   <= in_dividend;
      dvs_r[0]  <= in_divisor;
      side_r[0] <= in_side;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;

    always_comb begin
      trial = {rem_r[g], dq_r[g][31]};
      diff  = trial - {1'b0, dvs_r[g]};
      qbit  = !diff[32];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= qbit ? diff[31:0] : trial[31:0];
        dq_r[g+1]   <= {dq_r[g][30:0], qbit};
        dvs_r[g+1]  <= dvs_r[g];
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign out_valid    = vld_r[N];
  assign out_quotient = dq_r[N];
  assign out_side     = side_r[N];

endmodule
`default_nettype wire

[sv/baro_temp_compensation_core.sv]
// Top level: pipelined barometric temperature and pressure compensation.
//
//  Channel   Ports                     Contents (low bit first)
//  in        in_tvalid/tready/tdata    raw_temperature[15:0], raw_pressure[34:16]
//  out       out_tvalid/tready/tdata   temperature_tenths[15:0], pressure_pa[33:16]
//            out_tuser                 divide_error
//  cfg       cfg_we/index/data         calibration words and oversampling
//
// One beat enters per cycle while the output is not held. It passes 9 arithmetic
// stages, two 33-stage dividers (a quotient bit per stage) and the output register.
// The whole pipeline advances on one enable; a held output freezes every
// stage, so a stall neither drops nor repeats a beat. rst_n clears the valid
// bits and loads the datasheet calibration.
`default_nettype none
module baro_temp_compensation_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // raw_temperature, raw_pressure, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // temperature_tenths, pressure_pa, zero pad
  output logic             out_tuser,  // divide_error
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned SIDE1_W = 1 + 1 + 19 + 32;
  localparam int unsigned SIDE2_W = 32 + 1 + 1;

  // configuration registers
  logic [31:0] c_ac12_r, c_ac34_r, c_ac56_r, c_b12_r, c_mcmd_r;
  logic [1:0]  c_oss_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_ac12_r <= btc_pkg::RST_AC1_AC2;
      c_ac34_r <= btc_pkg::RST_AC3_AC4;
      c_ac56_r <= btc_pkg::RST_AC5_AC6;
      c_b12_r  <= btc_pkg::RST_B1_B2;
      c_mcmd_r <= btc_pkg::RST_MC_MD;
      c_oss_r  <= btc_pkg::RST_OSS;
    end else if (cfg_we) begin
      case (cfg_index)
        btc_pkg::REG_AC1_AC2: c_ac12_r <= cfg_data;
        btc_pkg::REG_AC3_AC4: c_ac34_r <= cfg_data;
        btc_pkg::REG_AC5_AC6: c_ac56_r <= cfg_data;
        btc_pkg::REG_B1_B2:   c_b12_r  <= cfg_data;
        btc_pkg::REG_MC_MD:   c_mcmd_r <= cfg_data;
        btc_pkg::REG_OSS:     c_oss_r  <= cfg_data[1:0];
        default: ; // drop writes past the register list
      endcase
    end
  end

  // unpacked coefficients
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = btc_pkg::sx16(c_ac12_r[31:16]);
  assign ac2 = btc_pkg::sx16(c_ac12_r[15:0]);
  assign ac3 = btc_pkg::sx16(c_ac34_r[31:16]);
  assign ac4 = {16'd0, c_ac34_r[15:0]};
  assign ac5 = {16'd0, c_ac56_r[31:16]};
  assign ac6 = {16'd0, c_ac56_r[15:0]};
  assign b1  = btc_pkg::sx16(c_b12_r[31:16]);
  assign b2  = btc_pkg::sx16(c_b12_r[15:0]);
  assign mc  = btc_pkg::sx16(c_mcmd_r[31:16]);
  assign md  = btc_pkg::sx16(c_mcmd_r[15:0]);

  // global advance: hold everything while a result waits unclaimed
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // ---------------- stage A: x1 = ((ut - ac6) * ac5) >> 15
  logic        v_a_r;
  logic [31:0] x1_a_r;
  logic [18:0] up_a_r;
  logic [31:0] ut_diff;
  assign ut_diff = {16'd0, in_tdata[15:0]} - ac6;

  always_ff @(posedge clk) begin
    if (!rst_n) v_a_r <= 1'b0;
    else if (en) v_a_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1_a_r <= btc_pkg::sra32(btc_pkg::mul_lo(ut_diff, ac5), 5'd15);
      up_a_r <= in_tdata[34:16];
    end
  end

  // ---------------- stage B: magnitudes into divider one, (mc << 11) / (x1 + md)
  logic [31:0] den, num, ua1, ub1;
  logic        err1;
  assign den  = x1_a_r + md;
  assign num  = {mc[20:0], 11'd0};
  assign ua1  = num[31] ? (32'd0 - num) : num;
  assign ub1  = den[31] ? (32'd0 - den) : den;
  assign err1 = (den == 32'd0);

  logic               d1_v;
  logic [31:0]        d1_q;
  logic [SIDE1_W-1:0] d1_s;

  btc_div_pipe #(.SIDE_W(SIDE1_W)) u_div_t (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v_a_r),
    .in_dividend (ua1),
    .in_divisor  (ub1),
    .in_side     ({err1, num[31] ^ den[31], up_a_r, x1_a_r}),
    .out_valid   (d1_v),
    .out_quotient(d1_q),
    .out_side    (d1_s)
  );

  // ---------------- stage C: b5, b6
  logic        v_c_r, err_c_r;
  logic [31:0] b5_c_r, b6_c_r;
  logic [18:0] up_c_r;
  logic [31:0] x2_t, b5_c;
  assign x2_t = d1_s[51] ? (32'd0 - d1_q) : d1_q;
  assign b5_c = d1_s[31:0] + x2_t;

  always_ff @(posedge clk) begin
    if (!rst_n) v_c_r <= 1'b0;
    else if (en) v_c_r <= d1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b5_c_r  <= b5_c;
      b6_c_r  <= b5_c - btc_pkg::K_B6_OFS;
      up_c_r  <= d1_s[50:32];
      err_c_r <= d1_s[52];
    end
  end

  // ---------------- stage D: b6*b6, ac2*b6, ac3*b6
  logic        v_d_r, err_d_r;
  logic [31:0] b5_d_r, msq_d_r, mac2_d_r, mac3_d_r;
  logic [18:0] up_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_d_r <= 1'b0;
    else if (en) v_d_r <= v_c_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      msq_d_r  <= btc_pkg::mul_lo(b6_c_r, b6_c_r);
      mac2_d_r <= btc_pkg::mul_lo(ac2, b6_c_r);
      mac3_d_r <= btc_pkg::mul_lo(ac3, b6_c_r);
      b5_d_r   <= b5_c_r;
      up_d_r   <= up_c_r;
      err_d_r  <= err_c_r;
    end
  end

  // ---------------- stage E: b2*sq, b1*sq
  logic        v_e_r, err_e_r;
  logic [31:0] b5_e_r, b2sq_e_r, b1sq_e_r, x2a_e_r, x1c_e_r;
  logic [18:0] up_e_r;
  logic [31:0] sq_e;
  assign sq_e = btc_pkg::sra32(msq_d_r, 5'd12);

  always_ff @(posedge clk) begin
    if (!rst_n) v_e_r <= 1'b0;
    else if (en) v_e_r <= v_d_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b2sq_e_r <= btc_pkg::mul_lo(b2, sq_e);
      b1sq_e_r <= btc_pkg::mul_lo(b1, sq_e);
      x2a_e_r  <= btc_pkg::sra32(mac2_d_r, 5'd11);
      x1c_e_r  <= btc_pkg::sra32(mac3_d_r, 5'd13);
      b5_e_r   <= b5_d_r;
      up_e_r   <= up_d_r;
      err_e_r  <= err_d_r;
    end
  end

  // ---------------- stage F: b3 and the b4 offset term
  logic        v_f_r, err_f_r;
  logic [31:0] b5_f_r, b3_f_r, x3b_f_r;
  logic [18:0] up_f_r;
  logic [31:0] x3_f, s_f, x3b_f;
  always_comb begin
    x3_f  = btc_pkg::sra32(b2sq_e_r, 5'd11) + x2a_e_r;
    s_f   = (({ac1[29:0], 2'd0} + x3_f) << c_oss_r) + 32'd2;
    x3b_f = btc_pkg::sra32(x1c_e_r + btc_pkg::sra32(b1sq_e_r, 5'd16) + 32'd2, 5'd2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_f_r <= 1'b0;
    else if (en) v_f_r <= v_e_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      // divide by four, truncating toward zero
      b3_f_r  <= btc_pkg::sra32(s_f + (s_f[31] ? 32'd3 : 32'd0), 5'd2);
      x3b_f_r <= x3b_f;
      b5_f_r  <= b5_e_r;
      up_f_r  <= up_e_r;
      err_f_r <= err_e_r;
    end
  end

  // ---------------- stage G: b4, up - b3
  logic        v_g_r, err_g_r;
  logic [31:0] b5_g_r, b4_g_r, dup_g_r;
  logic [31:0] b4p_g;
  assign b4p_g = btc_pkg::mul_lo(ac4, x3b_f_r + btc_pkg::K_HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) v_g_r <= 1'b0;
    else if (en) v_g_r <= v_f_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4_g_r  <= b4p_g >> 15;
      dup_g_r <= {13'd0, up_f_r} - b3_f_r;
      b5_g_r  <= b5_f_r;
      err_g_r <= err_f_r;
    end
  end

  // ---------------- stage H: b7
  logic        v_h_r, err_h_r;
  logic [31:0] b5_h_r, b4_h_r, b7_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_h_r <= 1'b0;
    else if (en) v_h_r <= v_g_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b7_h_r  <= btc_pkg::mul_lo(dup_g_r, btc_pkg::K_P_SCALE >> c_oss_r);
      b4_h_r  <= b4_g_r;
      b5_h_r  <= b5_g_r;
      err_h_r <= err_g_r;
    end
  end

  // ---------------- divider two: p = b7*2/b4, or (b7/b4)*2 when b7 has its top bit
  logic               d2_v;
  logic [31:0]        d2_q;
  logic [SIDE2_W-1:0] d2_s;
  logic [31:0]        dvd2;
  assign dvd2 = b7_h_r[31] ? b7_h_r : {b7_h_r[30:0], 1'b0};

  btc_div_pipe #(.SIDE_W(SIDE2_W)) u_div_p (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (v_h_r),
    .in_dividend (dvd2),
    .in_divisor  (b4_h_r),
    .in_side     ({b5_h_r, err_h_r || (b4_h_r == 32'd0), b7_h_r[31]}),
    .out_valid   (d2_v),
    .out_quotient(d2_q),
    .out_side    (d2_s)
  );

  // ---------------- stage I: (p>>8)^2 and -7357*p
  logic        v_i_r, err_i_r;
  logic [31:0] b5_i_r, p_i_r, m1_i_r, m2_i_r;
  logic [31:0] p_i, t8_i;
  assign p_i  = d2_s[0] ? {d2_q[30:0], 1'b0} : d2_q;
  assign t8_i = btc_pkg::sra32(p_i, 5'd8);

  always_ff @(posedge clk) begin
    if (!rst_n) v_i_r <= 1'b0;
    else if (en) v_i_r <= d2_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m1_i_r  <= btc_pkg::mul_lo(t8_i, t8_i);
      m2_i_r  <= btc_pkg::mul_lo(btc_pkg::K_CM7357, p_i);
      p_i_r   <= p_i;
      b5_i_r  <= d2_s[33:2];
      err_i_r <= d2_s[1];
    end
  end

  // ---------------- stage J: x1 * 3038
  logic        v_j_r, err_j_r;
  logic [31:0] b5_j_r, p_j_r, m3_j_r, x2_j_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v_j_r <= 1'b0;
    else if (en) v_j_r <= v_i_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m3_j_r  <= btc_pkg::mul_lo(m1_i_r, btc_pkg::K_C3038);
      x2_j_r  <= btc_pkg::sra32(m2_i_r, 5'd16);
      p_j_r   <= p_i_r;
      b5_j_r  <= b5_i_r;
      err_j_r <= err_i_r;
    end
  end

  // ---------------- stage K: final pressure, saturate both results, output register
  logic [31:0] pf_k, t_k;
  logic [17:0] pres_k;
  logic [15:0] temp_k;
  always_comb begin
    pf_k = p_j_r + btc_pkg::sra32(btc_pkg::sra32(m3_j_r, 5'd16) + x2_j_r
                                  + btc_pkg::K_C3791, 5'd4);
    t_k  = btc_pkg::sra32(b5_j_r + 32'd8, 5'd4);
    if (pf_k[31]) begin
      pres_k = 18'd0;
    end else if (pf_k > btc_pkg::P_MAX) begin
      pres_k = btc_pkg::P_MAX[17:0];
    end else begin
      pres_k = pf_k[17:0];
    end
    if ($signed(t_k) > 32'sd32767) begin
      temp_k = 16'h7FFF;
    end else if ($signed(t_k) < -32'sd32768) begin
      temp_k = 16'h8000;
    end else begin
      temp_k = t_k[15:0];
    end
  end

  logic [15:0] temp_r;
  logic [17:0] pres_r;
  logic        err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= v_j_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      temp_r <= err_j_r ? 16'd0 : temp_k;
      pres_r <= err_j_r ? 18'd0 : pres_k;
      err_r  <= err_j_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, pres_r, temp_r};
  assign out_tuser  = err_r;

  // ---------------- checks
  a_err_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 40'd0)
    else $error("divide error beat carries nonzero results");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_j_r) && $stable(p_j_r))
    else $error("pipeline moved during a stall");

endmodule
`default_nettype wire

[bench/baro_temp_compensation_core_tb.sv]
// Self-checking testbench for the barometric temperature and pressure compensation core.
`default_nettype none
module baro_temp_compensation_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY   = 76;
  localparam int N_RANDOM  = 550;
  localparam int MAX_CYCLE = 400000;

  typedef struct packed {
    logic [15:0] temp;
    logic [17:0] press;
    logic        div_err;
  } comp_result_t;

  typedef struct {
    logic [15:0] ut;
    logic [18:0] up;
    bit          known;    // expected value typed in the row
    comp_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // calibration copy for the predictor
  logic [31:0] cal_word [0:4];
  logic [1:0]  oss_sh;

  comp_result_t pending_results[$];
  int  errors = 0;
  int  cycle_cnt = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;

  baro_temp_compensation_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // hard limit on run length
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLE) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // signed divide truncating toward zero, -2^31 / -1 wraps
  function automatic logic [31:0] div_trunc(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ua, ub, q;
    ua = a[31] ? -a : a;
    ub = b[31] ? -b : b;
    q = ua / ub;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // compute compensated temperature and pressure for one reading pair
  function automatic comp_result_t compensate(input logic [15:0] ut_raw,
                                              input logic [18:0] up_raw);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, p, sq;
    comp_result_t r;
    ac1 = ext16(cal_word[btc_pkg::REG_AC1_AC2][31:16]);
    ac2 = ext16(cal_word[btc_pkg::REG_AC1_AC2][15:0]);
    ac3 = ext16(cal_word[btc_pkg::REG_AC3_AC4][31:16]);
    ac4 = {16'h0, cal_word[btc_pkg::REG_AC3_AC4][15:0]};
    ac5 = {16'h0, cal_word[btc_pkg::REG_AC5_AC6][31:16]};
    ac6 = {16'h0, cal_word[btc_pkg::REG_AC5_AC6][15:0]};
    b1  = ext16(cal_word[btc_pkg::REG_B1_B2][31:16]);
    b2  = ext16(cal_word[btc_pkg::REG_B1_B2][15:0]);
    mc  = ext16(cal_word[btc_pkg::REG_MC_MD][31:16]);
    md  = ext16(cal_word[btc_pkg::REG_MC_MD][15:0]);
    ut = {16'h0, ut_raw};
    up = {13'h0, up_raw};
    r = '0;
    x1 = asr((ut - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) begin
      r.div_err = 1'b1;
      return r;
    end
    x2 = div_trunc(mc << 11, den);
    b5 = x1 + x2;
    b6 = b5 - 32'd4000;
    sq = asr(b6 * b6, 12);
    x1 = asr(b2 * sq, 11);
    x2 = asr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = div_trunc(((ac1 * 32'd4 + x3) << oss_sh) + 32'd2, 32'd4);
    x1 = asr(ac3 * b6, 13);
    x2 = asr(b1 * sq, 16);
    x3 = asr(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + 32'd32768)) >> 15;
    if (b4 == 0) begin
      r.div_err = 1'b1;
      return r;
    end
    b7 = (up - b3) * (32'd50000 >> oss_sh);
    if (b7 < 32'h8000_0000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1 = asr(p, 8) * asr(p, 8);
    x1 = asr(x1 * 32'd3038, 16);
    x2 = asr((-32'd7357) * p, 16);
    p = p + asr(x1 + x2 + 32'd3791, 4);
    x3 = asr(b5 + 32'd8, 4);
    // saturate temperature to 16 signed bits, pressure to 0..262143
    if ($signed(x3) > 32767) r.temp = 16'h7FFF;
    else if ($signed(x3) < -32768) r.temp = 16'h8000;
    else r.temp = x3[15:0];
    if (p[31]) r.press = '0;
    else if (p > 32'd262143) r.press = 18'h3FFFF;
    else r.press = p[17:0];
    return r;
  endfunction

  // write one register; the block must be idle
  task automatic write_reg(input btc_pkg::cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == btc_pkg::REG_OSS) oss_sh = val[1:0];
    else cal_word[idx] = val;
  endtask

  // drop valid, hold until all expected beats are back, then let the pipe drain
  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // offer one beat and hold it until accepted
  task automatic send_beat(input logic [15:0] ut, input logic [18:0] up,
                           input bit known, input comp_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, up, ut};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(known ? res : compensate(ut, up));
  endtask

  // receiver: random backpressure, check each beat against oldest expectation
  always @(posedge clk) begin
    comp_result_t got, exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      got.temp = out_tdata[15:0];
      got.press = out_tdata[33:16];
      got.div_err = out_tuser;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.temp !== exp_r.temp) begin
          $display("%0t: temperature exp %h got %h", $time, exp_r.temp, got.temp);
          errors++;
        end
        if (got.press !== exp_r.press) begin
          $display("%0t: pressure exp %h got %h", $time, exp_r.press, got.press);
          errors++;
        end
        if (got.div_err !== exp_r.div_err) begin
          $display("%0t: divide_error exp %b got %b", $time, exp_r.div_err, got.div_err);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic random_beats(input int n);
    logic [15:0] ut;
    logic [18:0] up;
    for (int i = 0; i < n; i++) begin
      // mostly plausible readings, sometimes the full field range
      if ($urandom_range(3) == 0) begin
        ut = 16'($urandom);
        up = 19'($urandom);
      end else begin
        ut = 16'($urandom_range(36000, 20000));
        up = 19'($urandom_range(100000, 10000) << oss_sh);
      end
      send_beat(ut, up, 1'b0, '0);
    end
  endtask

  // random calibration: some words replaced by fully random values, then a random oss
  task automatic random_cal;
    for (int r = 0; r < 5; r++) begin
      if ($urandom_range(2) == 0) write_reg(btc_pkg::cfg_reg_t'(r), $urandom);
    end
    write_reg(btc_pkg::REG_OSS, $urandom_range(3));
  endtask

  stim_row_t rows[$];

  initial begin
    cal_word[0] = btc_pkg::RST_AC1_AC2;
    cal_word[1] = btc_pkg::RST_AC3_AC4;
    cal_word[2] = btc_pkg::RST_AC5_AC6;
    cal_word[3] = btc_pkg::RST_B1_B2;
    cal_word[4] = btc_pkg::RST_MC_MD;
    oss_sh = btc_pkg::RST_OSS;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // datasheet example: ut 27898, up 23843 gives 150 and 69964
    rows.push_back('{16'd27898, 19'd23843, 1'b1, '{16'd150, 18'd69964, 1'b0}});
    rows.push_back('{16'h0000, 19'h00000, 1'b0, '0});
    rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, '0});
    rows.push_back('{16'h0000, 19'h7FFFF, 1'b0, '0});
    rows.push_back('{16'hFFFF, 19'h00000, 1'b0, '0});
    rows.push_back('{16'h5555, 19'h2AAAA, 1'b0, '0});
    rows.push_back('{16'hAAAA, 19'h55555, 1'b0, '0});
    foreach (rows[i]) send_beat(rows[i].ut, rows[i].up, rows[i].known, rows[i].res);
    drain();

    // zero temperature divisor: ac5 = 0 makes x1 = 0, md = 0
    write_reg(btc_pkg::REG_AC5_AC6, 32'h0000_5A71);
    write_reg(btc_pkg::REG_MC_MD, 32'hDDF9_0000);
    send_beat(16'd27898, 19'd23843, 1'b1, '{16'd0, 18'd0, 1'b1});
    send_beat(16'hFFFF, 19'h7FFFF, 1'b1, '{16'd0, 18'd0, 1'b1});
    drain();
    // zero pressure divisor: ac4 = 0
    write_reg(btc_pkg::REG_AC5_AC6, btc_pkg::RST_AC5_AC6);
    write_reg(btc_pkg::REG_MC_MD, btc_pkg::RST_MC_MD);
    write_reg(btc_pkg::REG_AC3_AC4, 32'hC7D1_0000);
    send_beat(16'd27898, 19'd23843, 1'b1, '{16'd0, 18'd0, 1'b1});
    drain();
    // extreme calibration words, every oss
    write_reg(btc_pkg::REG_AC1_AC2, 32'h7FFF_8000);
    write_reg(btc_pkg::REG_AC3_AC4, 32'h8000_FFFF);
    write_reg(btc_pkg::REG_AC5_AC6, 32'hFFFF_0000);
    write_reg(btc_pkg::REG_B1_B2, 32'h8000_7FFF);
    write_reg(btc_pkg::REG_MC_MD, 32'h7FFF_8000);
    for (int o = 0; o < 4; o++) begin
      write_reg(btc_pkg::REG_OSS, o);
      send_beat(16'h0000, 19'h7FFFF, 1'b0, '0);
      send_beat(16'hFFFF, 19'h00000, 1'b0, '0);
      send_beat(16'h8000, 19'h40000, 1'b0, '0);
      drain();
    end
    write_reg(btc_pkg::REG_AC1_AC2, 32'h0000_0000);
    write_reg(btc_pkg::REG_AC3_AC4, 32'hFFFF_0001);
    write_reg(btc_pkg::REG_B1_B2, 32'hFFFF_0000);
    write_reg(btc_pkg::REG_MC_MD, 32'h8000_7FFF);
    send_beat(16'h1234, 19'h3ABCD, 1'b0, '0);
    drain();
    // back to datasheet set for the first random phase
    write_reg(btc_pkg::REG_AC1_AC2, btc_pkg::RST_AC1_AC2);
    write_reg(btc_pkg::REG_AC3_AC4, btc_pkg::RST_AC3_AC4);
    write_reg(btc_pkg::REG_AC5_AC6, btc_pkg::RST_AC5_AC6);
    write_reg(btc_pkg::REG_B1_B2, btc_pkg::RST_B1_B2);
    write_reg(btc_pkg::REG_MC_MD, btc_pkg::RST_MC_MD);
    write_reg(btc_pkg::REG_OSS, 32'd3);

    // three idling phases, each split in chunks with new calibration
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 81 : 0;
      recv_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 12 : 0;
      for (int c = 0; c < 3; c++) begin
        random_beats(N_RANDOM / 9);
        drain();
        random_cal();
      end
    end

    drain();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
